// ===== sv/page_buffer_pool_lru_assert.svh =====
// Assertion macros for the page buffer pool directory
`ifndef PAGE_BUFFER_POOL_LRU_ASSERT_SVH
`define PAGE_BUFFER_POOL_LRU_ASSERT_SVH
// implication checked on every clock edge outside reset
`define PBP_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// implication checked in the following cycle
`define PBP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

// ===== sv/pbp_pkg.sv =====
// Shared types and constants of the page buffer pool directory
package pbp_pkg;
    localparam int NUM_FRAMES = 32;
    localparam int PAGE_BITS  = 24;
    localparam int MAX_TABLES = 10;
    localparam int FRAME_W    = $clog2(NUM_FRAMES);
    localparam int CNT_W      = $clog2(NUM_FRAMES + 1);

    typedef enum logic [1:0] {
        KIND_READ      = 2'd0,
        KIND_WRITE     = 2'd1,
        KIND_FLUSH_TAB = 2'd2,
        KIND_FLUSH_ALL = 2'd3
    } kind_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [3:0]  table_number;
        logic [23:0] page_number;
    } req_t;

    typedef struct packed {
        logic [5:0]  frame_index;
        logic        hit;
        logic        fetch_needed;
        logic        writeback_valid;
        logic [3:0]  writeback_table;
        logic [23:0] writeback_page;
        logic        last;
    } rsp_t;

    // controller -> datapath
    typedef struct packed {
        logic load_req;    // capture request word
        logic access;      // perform read/write lookup and update
        logic scan_start;  // clear scan pointer
        logic scan_step;   // examine frame at pointer, advance
        logic emit_empty;  // produce the empty-flush word
        logic out_take;    // output register consumed
    } dp_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic req_is_flush;
        logic scan_done;   // pointer at final frame
        logic out_full;
        logic flush_any;   // at least one frame due for writeback
    } dp_sts_t;
endpackage

// ===== sv/pbp_if.sv =====
// Valid/ready stream interface
interface pbp_req_if;
    pbp_pkg::req_t data;
    logic valid;
    logic ready;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface pbp_rsp_if;
    pbp_pkg::rsp_t data;
    logic valid;
    logic ready;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== sv/pbp_datapath.sv =====
// Frame directory storage, lookup, LRU update and flush scan
module pbp_datapath (
    input  logic             clk,
    input  logic             rst_n,
    input  pbp_pkg::req_t    req,
    input  pbp_pkg::dp_cmd_t cmd,
    output pbp_pkg::dp_sts_t sts,
    output pbp_pkg::rsp_t    rsp
);
    localparam int NF = pbp_pkg::NUM_FRAMES;
    localparam int FW = pbp_pkg::FRAME_W;
    localparam int PB = pbp_pkg::PAGE_BITS;

    logic [NF-1:0]          valid_reg;
    logic [NF-1:0]          dirty_reg;
    logic [3:0]             tab_reg  [NF];
    logic [PB-1:0]          page_reg [NF];
    logic [FW-1:0]          rank_reg [NF];
    pbp_pkg::req_t          req_reg;
    pbp_pkg::rsp_t          rsp_reg;
    logic                   full_reg;
    logic [FW-1:0]          ptr_reg;

    logic [PB-1:0]          key_page;
    logic [NF-1:0]          match;
    logic [NF-1:0]          elig;
    logic                   later_any;
    logic                   is_hit;
    logic [FW-1:0]          hit_f;
    logic [FW-1:0]          lru_f;
    logic [FW-1:0]          sel_f;
    logic                   sel_dirty;
    logic                   flush_sel;
    logic                   is_write;

    assign key_page = req_reg.page_number[PB-1:0];
    assign is_write = (req_reg.kind == pbp_pkg::KIND_WRITE);

    always_comb
    begin
        hit_f = '0;
        lru_f = '0;
        is_hit = 1'b0;
        later_any = 1'b0;
        for (int i = NF - 1; i >= 0; i--)
        begin
            match[i] = valid_reg[i] && tab_reg[i] == req_reg.table_number
                       && page_reg[i] == key_page;
            if (match[i])
            begin
                hit_f = FW'(i);
                is_hit = 1'b1;
            end
            if (rank_reg[i] == FW'(NF - 1))
                lru_f = FW'(i);
            // frames a flush must write back
            elig[i] = valid_reg[i] && dirty_reg[i]
                      && (req_reg.kind == pbp_pkg::KIND_FLUSH_ALL
                          || tab_reg[i] == req_reg.table_number);
            if (elig[i] && FW'(i) > ptr_reg)
                later_any = 1'b1;
        end
        sel_f = is_hit ? hit_f : lru_f;
        sel_dirty = valid_reg[sel_f] && dirty_reg[sel_f];
        flush_sel = elig[ptr_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg   <= '0;
            dirty_reg   <= '0;
            full_reg    <= 1'b0;
            ptr_reg     <= '0;
            for (int i = 0; i < NF; i++)
            begin
                tab_reg[i]  <= '0;
                page_reg[i] <= '0;
                rank_reg[i] <= FW'(i);
            end
        end
        else
        begin
            if (cmd.out_take)
                full_reg <= 1'b0;
            if (cmd.access)
            begin
                for (int i = 0; i < NF; i++)
                    if (rank_reg[i] < rank_reg[sel_f])
                        rank_reg[i] <= rank_reg[i] + FW'(1);
                rank_reg[sel_f] <= '0;
                if (!is_hit)
                begin
                    valid_reg[sel_f] <= 1'b1;
                    tab_reg[sel_f]   <= req_reg.table_number;
                    page_reg[sel_f]  <= key_page;
                end
                dirty_reg[sel_f] <= is_write || (is_hit && dirty_reg[sel_f]);
                full_reg <= 1'b1;
            end
            if (cmd.scan_start)
                ptr_reg <= '0;
            if (cmd.scan_step)
            begin
                ptr_reg <= ptr_reg + FW'(1);
                if (flush_sel)
                    full_reg <= 1'b1;
            end
            if (cmd.emit_empty)
                full_reg <= 1'b1;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.load_req)
            req_reg <= req;
        if (cmd.access)
        begin
            rsp_reg.frame_index     <= 6'(sel_f);
            rsp_reg.hit             <= is_hit;
            rsp_reg.fetch_needed    <= !is_hit && !is_write;
            rsp_reg.writeback_valid <= !is_hit && sel_dirty;
            rsp_reg.writeback_table <= (!is_hit && sel_dirty) ? tab_reg[sel_f] : 4'd0;
            rsp_reg.writeback_page  <= (!is_hit && sel_dirty) ? 24'(page_reg[sel_f]) : 24'd0;
            rsp_reg.last            <= 1'b1;
        end
        else if (cmd.scan_step && flush_sel)
        begin
            // last when no due frame lies beyond the pointer
            rsp_reg.frame_index     <= 6'(ptr_reg);
            rsp_reg.hit             <= 1'b0;
            rsp_reg.fetch_needed    <= 1'b0;
            rsp_reg.writeback_valid <= 1'b1;
            rsp_reg.writeback_table <= tab_reg[ptr_reg];
            rsp_reg.writeback_page  <= 24'(page_reg[ptr_reg]);
            rsp_reg.last            <= !later_any;
        end
        else if (cmd.emit_empty)
        begin
            rsp_reg.frame_index     <= '0;
            rsp_reg.hit             <= 1'b0;
            rsp_reg.fetch_needed    <= 1'b0;
            rsp_reg.writeback_valid <= 1'b0;
            rsp_reg.writeback_table <= '0;
            rsp_reg.writeback_page  <= '0;
            rsp_reg.last            <= 1'b1;
        end
    end

    assign sts.req_is_flush = req_reg.kind[1];
    assign sts.scan_done    = (ptr_reg == FW'(NF - 1));
    assign sts.out_full     = full_reg;
    assign sts.flush_any    = |elig;
    assign rsp = rsp_reg;
endmodule

// ===== sv/pbp_ctrl.sv =====
// Sequencing state machine of the page buffer pool directory
module pbp_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic             out_ready,
    input  pbp_pkg::dp_sts_t sts,
    output pbp_pkg::dp_cmd_t cmd
);
    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_EXEC = 3'b010,
        ST_SCAN = 3'b100
    } state_t;

    state_t state_reg, state_next;
    logic   take;

    assign take = sts.out_full && out_ready;

    always_comb
    begin
        cmd = '0;
        cmd.out_take = take;
        state_next = state_reg;
        in_ready = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = !sts.out_full || out_ready;
                if (in_valid && in_ready)
                begin
                    cmd.load_req = 1'b1;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (!sts.req_is_flush || !sts.flush_any)
                begin
                    // lookup, or the empty-flush word
                    if (!sts.out_full || out_ready)
                    begin
                        cmd.access = !sts.req_is_flush;
                        cmd.emit_empty = sts.req_is_flush;
                        state_next = ST_IDLE;
                    end
                end
                else
                begin
                    cmd.scan_start = 1'b1;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                // a found word sits in the output register; wait till it leaves
                if (!sts.out_full || out_ready)
                begin
                    cmd.scan_step = 1'b1;
                    if (sts.scan_done)
                        state_next = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end
endmodule

// ===== sv/page_buffer_pool_lru.sv =====
// Top level of the page buffer pool directory
// LRU frame directory for a 32-frame buffer pool. A read or write word
// is captured, then a parallel tag match over all frames and a rank
// update are done in one step. A flush with dirty matching frames walks
// every frame one per cycle, stalling while a found word waits in the
// output register; each dirty matching frame yields one writeback word, the
// final one flagged last. A flush with nothing dirty yields one all-zero
// word with last set. The output register holds the result until taken;
// a new word is taken only once the previous one has fully left the
// directory.
module page_buffer_pool_lru (
    input  logic         clk,
    input  logic         rst_n,
    pbp_req_if.sink      req,
    pbp_rsp_if.source    rsp
);
    pbp_pkg::dp_cmd_t cmd;
    pbp_pkg::dp_sts_t sts;
    pbp_pkg::rsp_t    rsp_word;

    pbp_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (req.valid),
        .in_ready (req.ready),
        .out_ready(rsp.ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    pbp_datapath u_dp (
        .clk  (clk),
        .rst_n(rst_n),
        .req  (req.data),
        .cmd  (cmd),
        .sts  (sts),
        .rsp  (rsp_word)
    );

    // last is known as each flush word is found, so words go out at once
    assign rsp.data  = rsp_word;
    assign rsp.valid = sts.out_full;

    `include "page_buffer_pool_lru_assert.svh"
    `PBP_ASSERT_IMP(a_ready_idle, req.ready, !sts.out_full || rsp.ready,
        "input taken while output blocked")
    `PBP_ASSERT_IMP(a_flush_nohit, rsp.valid && rsp.data.writeback_valid && sts.req_is_flush,
        !rsp.data.hit && !rsp.data.fetch_needed, "flush word flagged as hit")
    `PBP_ASSERT_NEXT(a_rsp_hold, rsp.valid && !rsp.ready,
        rsp.valid && $stable(rsp.data), "waiting word changed")
endmodule

// ===== sim/tb_pbp_if_note.sv =====
`timescale 1ns / 1ps
// Clock-independent helper types for the page buffer pool testbench
package tb_pbp_pkg;
    import pbp_pkg::*;

    // one expected response word
    typedef struct {
        logic [5:0]  frame_index;
        logic        hit;
        logic        fetch_needed;
        logic        writeback_valid;
        logic [3:0]  writeback_table;
        logic [23:0] writeback_page;
        logic        last;
    } exp_word_t;
endpackage

// ===== sim/tb.sv =====
`timescale 1ns / 1ps
// Testbench top for the page buffer pool LRU directory
module tb;
    import pbp_pkg::*;
    import tb_pbp_pkg::*;

    logic clk;
    logic rst_n;

    pbp_req_if req_if ();
    pbp_rsp_if rsp_if ();

    page_buffer_pool_lru dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_if.sink),
        .rsp   (rsp_if.source)
    );

    // Shadow copy of the frame directory
    logic        fr_valid [NUM_FRAMES];
    logic [3:0]  fr_table [NUM_FRAMES];
    logic [23:0] fr_page  [NUM_FRAMES];
    logic        fr_dirty [NUM_FRAMES];
    int          fr_rank  [NUM_FRAMES];

    req_t      pending_words [$];
    exp_word_t expected_words [$];

    int    error_count;
    int    cycle_count;
    bit    quiet_phase;       // stretch with no idling on either side
    bit    stimulus_done;
    bit    timed_out;

    localparam int CYCLE_LIMIT = 400000;

    initial begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // -------------------------------------------------------------
    // Predictor
    // -------------------------------------------------------------
    function automatic void reset_directory();
        for (int f = 0; f < NUM_FRAMES; f++) begin
            fr_valid[f] = 1'b0;
            fr_table[f] = '0;
            fr_page[f]  = '0;
            fr_dirty[f] = 1'b0;
            fr_rank[f]  = f;    // last frame is oldest
        end
    endfunction

    // make frame most recent; younger frames age by one
    function automatic void promote_frame(int f);
        int old;
        old = fr_rank[f];
        for (int i = 0; i < NUM_FRAMES; i++)
            if (fr_rank[i] < old)
                fr_rank[i]++;
        fr_rank[f] = 0;
    endfunction

    function automatic void predict_lookup(req_t w);
        exp_word_t e;
        int        f;
        f = -1;
        e = '{default: '0};
        for (int i = 0; i < NUM_FRAMES; i++)
            if (f < 0 && fr_valid[i] && fr_table[i] == w.table_number
                && fr_page[i] == w.page_number)
                f = i;
        if (f >= 0) begin
            e.hit = 1'b1;
        end
        else begin
            f = 0;
            for (int i = 0; i < NUM_FRAMES; i++)
                if (fr_rank[i] > fr_rank[f])
                    f = i;
            if (fr_valid[f] && fr_dirty[f]) begin
                e.writeback_valid = 1'b1;
                e.writeback_table = fr_table[f];
                e.writeback_page  = fr_page[f];
            end
            fr_dirty[f] = 1'b0;
            fr_valid[f] = 1'b1;
            fr_table[f] = w.table_number;
            fr_page[f]  = w.page_number;
            e.fetch_needed = (w.kind == KIND_READ);
        end
        promote_frame(f);
        if (w.kind == KIND_WRITE)
            fr_dirty[f] = 1'b1;
        e.frame_index = 6'(f);
        e.last        = 1'b1;
        expected_words.push_back(e);
    endfunction

    // flushes keep dirty marks and recency
    function automatic void predict_flush(req_t w);
        exp_word_t e;
        int        n;
        n = 0;
        for (int i = 0; i < NUM_FRAMES; i++) begin
            if (fr_valid[i] && fr_dirty[i]
                && (w.kind == KIND_FLUSH_ALL || fr_table[i] == w.table_number)) begin
                e = '{default: '0};
                e.frame_index     = 6'(i);
                e.writeback_valid = 1'b1;
                e.writeback_table = fr_table[i];
                e.writeback_page  = fr_page[i];
                expected_words.push_back(e);
                n++;
            end
        end
        if (n == 0) begin
            e = '{default: '0};
            e.last = 1'b1;
            expected_words.push_back(e);
        end
        else begin
            expected_words[$].last = 1'b1;
        end
    endfunction

    task automatic report_mismatch(string msg);
        $display("mismatch @%0t: %s", $realtime, msg);
        error_count++;
    endtask

    // -------------------------------------------------------------
    // Driver: requests leave the queue at accepted handshakes
    // -------------------------------------------------------------
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            req_if.valid <= 1'b0;
            req_if.data  <= '0;
        end
        else begin
            if (req_if.valid && req_if.ready) begin
                case (req_if.data.kind)
                    KIND_READ, KIND_WRITE: predict_lookup(req_if.data);
                    default:               predict_flush(req_if.data);
                endcase
                void'(pending_words.pop_front());
            end
            // next word, if any, after an occasional idle cycle
            if (!req_if.valid || req_if.ready) begin
                if (pending_words.size() != 0
                    && (quiet_phase || $urandom_range(99) >= 9)) begin
                    req_if.valid <= 1'b1;
                    req_if.data  <= pending_words[0];
                end
                else begin
                    req_if.valid <= 1'b0;
                end
            end
        end
    end

    // -------------------------------------------------------------
    // Monitor and response-side stall
    // -------------------------------------------------------------
    always @(posedge clk or negedge rst_n) begin
        exp_word_t e;
        rsp_t      r;
        if (!rst_n) begin
            rsp_if.ready <= 1'b0;
            cycle_count  <= 0;
        end
        else begin
            cycle_count  <= cycle_count + 1;
            rsp_if.ready <= quiet_phase || ($urandom_range(99) >= 9);
            if (rsp_if.valid && rsp_if.ready) begin
                r = rsp_if.data;
                if (expected_words.size() == 0) begin
                    report_mismatch($sformatf("unexpected word frame %0d", r.frame_index));
                end
                else begin
                    e = expected_words.pop_front();
                    if (r.frame_index !== e.frame_index)
                        report_mismatch($sformatf("frame_index %0d, want %0d",
                                                  r.frame_index, e.frame_index));
                    if (r.hit !== e.hit)
                        report_mismatch($sformatf("hit %0b, want %0b", r.hit, e.hit));
                    if (r.fetch_needed !== e.fetch_needed)
                        report_mismatch($sformatf("fetch_needed %0b, want %0b",
                                                  r.fetch_needed, e.fetch_needed));
                    if (r.writeback_valid !== e.writeback_valid)
                        report_mismatch($sformatf("writeback_valid %0b, want %0b",
                                                  r.writeback_valid, e.writeback_valid));
                    if (r.writeback_table !== e.writeback_table)
                        report_mismatch($sformatf("writeback_table %0d, want %0d",
                                                  r.writeback_table, e.writeback_table));
                    if (r.writeback_page !== e.writeback_page)
                        report_mismatch($sformatf("writeback_page %0h, want %0h",
                                                  r.writeback_page, e.writeback_page));
                    if (r.last !== e.last)
                        report_mismatch($sformatf("last %0b, want %0b", r.last, e.last));
                end
            end
        end
    end

    // -------------------------------------------------------------
    // Stimulus
    // -------------------------------------------------------------
    function automatic req_t make_word(kind_t k, int t, logic [23:0] p);
        req_t w;
        w.kind         = k;
        w.table_number = 4'(t);
        w.page_number  = p;
        return w;
    endfunction

    // random page drawn mostly from a small working set so hits and dirty
    // evictions are frequent; now and then a fully random page
    function automatic req_t random_word();
        int    sel;
        kind_t k;
        logic [23:0] p;
        sel = $urandom_range(99);
        if (sel < 45)      k = KIND_READ;
        else if (sel < 88) k = KIND_WRITE;
        else if (sel < 96) k = KIND_FLUSH_TAB;
        else               k = KIND_FLUSH_ALL;
        if ($urandom_range(9) == 0)
            p = 24'($urandom);
        else
            p = 24'($urandom_range(47)) ^ ($urandom_range(1) ? 24'hA5_0000 : 24'h0);
        return make_word(k, $urandom_range(15), p);
    endfunction

    initial begin
        int wait_cycles;
        error_count   = 0;
        quiet_phase   = 1'b0;
        stimulus_done = 1'b0;
        reset_directory();
        rst_n = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // directed: flush of an empty pool, extremes of every field
        pending_words.push_back(make_word(KIND_FLUSH_ALL, 0, 24'h0));
        pending_words.push_back(make_word(KIND_FLUSH_TAB, 15, 24'hFFFFFF));
        pending_words.push_back(make_word(KIND_READ, 0, 24'h000000));
        pending_words.push_back(make_word(KIND_WRITE, 15, 24'hFFFFFF));
        pending_words.push_back(make_word(KIND_READ, 15, 24'hFFFFFF));   // hit on dirty
        pending_words.push_back(make_word(KIND_WRITE, 0, 24'h000000));   // write hit
        pending_words.push_back(make_word(KIND_READ, 9, 24'h555555));
        pending_words.push_back(make_word(KIND_WRITE, 10, 24'hAAAAAA));
        pending_words.push_back(make_word(KIND_READ, 0, 24'hFFFFFF));    // same page, other table
        pending_words.push_back(make_word(KIND_FLUSH_TAB, 15, 24'h0));
        pending_words.push_back(make_word(KIND_FLUSH_TAB, 3, 24'h0));    // nothing dirty there
        pending_words.push_back(make_word(KIND_FLUSH_ALL, 7, 24'h123456));
        // fill every frame dirty so eviction writes back, then flush all 32
        for (int i = 0; i < NUM_FRAMES + 2; i++)
            pending_words.push_back(make_word(KIND_WRITE, i % 16, 24'(i + 100)));
        pending_words.push_back(make_word(KIND_FLUSH_ALL, 0, 24'h0));

        // random part, with a no-idle stretch in the middle
        for (int i = 0; i < 250; i++)
            pending_words.push_back(random_word());
        wait (pending_words.size() < 200);
        quiet_phase = 1'b1;
        wait (pending_words.size() < 110);
        quiet_phase = 1'b0;
        wait (pending_words.size() == 0);
        wait (expected_words.size() == 0);
        wait_cycles = 0;
        while (wait_cycles < 60) begin
            @(posedge clk);
            wait_cycles++;
        end
        stimulus_done = 1'b1;
    end

    // single place that ends the run
    initial begin
        wait (stimulus_done || cycle_count >= CYCLE_LIMIT);
        if (!stimulus_done) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("** page_buffer_pool_lru: FAILED **");
        end
        else if (error_count == 0 && expected_words.size() == 0) begin
            $display("** page_buffer_pool_lru: PASSED **");
        end
        else begin
            $display("** page_buffer_pool_lru: FAILED **");
        end
        $finish;
    end
endmodule
